// ===== src/gncg_pkg.sv =====
// Package for the grid neighbour coordinate generator: widths, codes, stage payloads
// and the shared remainder step.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package gncg_pkg;

   // Largest grid side; larger register values act as this.
   localparam int MAX_DIM = 1024;
   localparam int COORD_W = 10;
   localparam int SIZE_W  = 11;
   localparam int MOD_W   = 12;

   typedef enum logic [1:0] {
      EDGE_TORUS   = 2'd0,
      EDGE_CLAMP   = 2'd1,
      EDGE_REFLECT = 2'd2,
      EDGE_ABSORB  = 2'd3
   } edge_mode_type;

   typedef enum logic {
      NBR_MOORE       = 1'b0,
      NBR_VON_NEUMANN = 1'b1
   } nbr_kind_type;

   typedef enum logic [1:0] {
      REG_GRID_WIDTH  = 2'd0,
      REG_GRID_HEIGHT = 2'd1,
      REG_EDGE_MODE   = 2'd2,
      REG_NBR_KIND    = 2'd3
   } reg_index_type;

   // Offset codes along one axis: -1, 0, +1
   localparam logic [1:0] OFF_NEG  = 2'd0;
   localparam logic [1:0] OFF_ZERO = 2'd1;
   localparam logic [1:0] OFF_POS  = 2'd2;

   // Effective configuration seen by every stage
   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      logic [MOD_W-1:0]  mod_x;
      logic [MOD_W-1:0]  mod_y;
      edge_mode_type     edge_mode;
      nbr_kind_type      kind;
   } cfg_type;

   // Centre coordinates with their running remainders
   typedef struct packed {
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [MOD_W-1:0]   rx;
      logic [MOD_W-1:0]   ry;
   } rem_type;

   // Mapped coordinates per offset code, with inside flags for absorbing borders
   typedef struct packed {
      logic [2:0][COORD_W-1:0] nx;
      logic [2:0][COORD_W-1:0] ny;
      logic [2:0]              okx;
      logic [2:0]              oky;
   } nbr_type;

   // Restoring remainder over up to four dividend bits, most significant first.
   // The running remainder stays below the modulus, so the shift drops a zero.
   function automatic logic [MOD_W-1:0] rem_chunk(input logic [MOD_W-1:0] r_start,
                                                  input logic [3:0]       bits,
                                                  input logic [2:0]       n_bits,
                                                  input logic [MOD_W-1:0] modulus);
      logic [MOD_W-1:0] r;
      r = r_start;
      for (int i = 3; i >= 0; i--) begin
         if (i < int'(n_bits)) begin
            r = {r[MOD_W-2:0], bits[i]};
            if (r >= modulus) begin
               r = r - modulus;
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/gncg_rem_pipe.sv =====
// Three-stage pipelined remainder of the centre coordinates by the axis modulus.
// Depends on gncg_pkg.
`default_nettype none

module gncg_rem_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gncg_pkg::cfg_type cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [9:0]        in_cx,
   input  wire logic [9:0]        in_cy,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output gncg_pkg::rem_type      out_data
);

   logic [2:0]        valid_ff;
   logic [2:0]        valid_in;
   logic [2:0]        load;
   gncg_pkg::rem_type pl_ff [3];
   gncg_pkg::rem_type pl_in [3];

   // A stage loads when empty or when its content moves on
   assign load[2]  = !valid_ff[2] || out_ready;
   assign load[1]  = !valid_ff[1] || load[2];
   assign load[0]  = !valid_ff[0] || load[1];
   assign in_ready = load[0];

   // Bits 9..6, then 5..3, then 2..0 of each coordinate
   always_comb begin
      pl_in[0].cx = in_cx;
      pl_in[0].cy = in_cy;
      pl_in[0].rx = gncg_pkg::rem_chunk('0, in_cx[9:6], 3'd4, cfg.mod_x);
      pl_in[0].ry = gncg_pkg::rem_chunk('0, in_cy[9:6], 3'd4, cfg.mod_y);

      pl_in[1]    = pl_ff[0];
      pl_in[1].rx = gncg_pkg::rem_chunk(pl_ff[0].rx, {1'b0, pl_ff[0].cx[5:3]}, 3'd3,
                                        cfg.mod_x);
      pl_in[1].ry = gncg_pkg::rem_chunk(pl_ff[0].ry, {1'b0, pl_ff[0].cy[5:3]}, 3'd3,
                                        cfg.mod_y);

      pl_in[2]    = pl_ff[1];
      pl_in[2].rx = gncg_pkg::rem_chunk(pl_ff[1].rx, {1'b0, pl_ff[1].cx[2:0]}, 3'd3,
                                        cfg.mod_x);
      pl_in[2].ry = gncg_pkg::rem_chunk(pl_ff[1].ry, {1'b0, pl_ff[1].cy[2:0]}, 3'd3,
                                        cfg.mod_y);
   end

   // Advance valid bits with the data
   always_comb begin
      valid_in[0] = load[0] ? in_valid    : valid_ff[0];
      valid_in[1] = load[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = load[2] ? valid_ff[1] : valid_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload while stalled
   always_ff @(posedge clock) begin
      if (load[0]) begin
         pl_ff[0] <= pl_in[0];
      end
      if (load[1]) begin
         pl_ff[1] <= pl_in[1];
      end
      if (load[2]) begin
         pl_ff[2] <= pl_in[2];
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = pl_ff[2];

endmodule

`default_nettype wire

// ===== src/gncg_map.sv =====
// Border mapping stage: turns centre and remainders into the three mapped values
// per axis and their inside flags. Depends on gncg_pkg.
`default_nettype none

module gncg_map (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gncg_pkg::cfg_type cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire gncg_pkg::rem_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output gncg_pkg::nbr_type      out_data
);

   typedef struct packed {
      logic [2:0][gncg_pkg::COORD_W-1:0] v;
      logic [2:0]                        ok;
   } axis_type;

   logic              valid_ff;
   logic              load;
   gncg_pkg::nbr_type pl_ff;
   gncg_pkg::nbr_type pl_in;
   axis_type          ax;
   axis_type          ay;

   // Mirror a value of one period of 2*size back into the grid
   function automatic logic [gncg_pkg::COORD_W-1:0] fold(
         input logic [gncg_pkg::MOD_W-1:0]  x,
         input logic [gncg_pkg::SIZE_W-1:0] size,
         input logic [gncg_pkg::MOD_W-1:0]  modulus);
      logic [gncg_pkg::MOD_W-1:0] f;
      f = (x >= {1'b0, size}) ? (modulus - 12'd1 - x) : x;
      return f[gncg_pkg::COORD_W-1:0];
   endfunction

   // Clamp an extended coordinate to the last row or column
   function automatic logic [gncg_pkg::COORD_W-1:0] clamp_hi(
         input logic [gncg_pkg::SIZE_W-1:0] x,
         input logic [gncg_pkg::SIZE_W-1:0] size_last);
      logic [gncg_pkg::SIZE_W-1:0] f;
      f = (x > size_last) ? size_last : x;
      return f[gncg_pkg::COORD_W-1:0];
   endfunction

   function automatic axis_type map_axis(input logic [gncg_pkg::COORD_W-1:0] c,
                                         input logic [gncg_pkg::SIZE_W-1:0]  size,
                                         input logic [gncg_pkg::MOD_W-1:0]   modulus,
                                         input logic [gncg_pkg::MOD_W-1:0]   r,
                                         input gncg_pkg::edge_mode_type      mode);
      axis_type                         a;
      logic [2:0][gncg_pkg::MOD_W-1:0]  wrap;
      logic [gncg_pkg::SIZE_W-1:0]      c_ext;
      logic [gncg_pkg::SIZE_W-1:0]      c_dec;
      logic [gncg_pkg::SIZE_W-1:0]      c_inc;
      logic [gncg_pkg::SIZE_W-1:0]      size_last;
      c_ext     = {1'b0, c};
      c_dec     = c_ext - 11'd1;
      c_inc     = c_ext + 11'd1;
      size_last = size - 11'd1;
      // Step the remainder by one either way within the period
      wrap[gncg_pkg::OFF_NEG]  = (r == '0) ? (modulus - 12'd1) : (r - 12'd1);
      wrap[gncg_pkg::OFF_ZERO] = r;
      wrap[gncg_pkg::OFF_POS]  = ((r + 12'd1) == modulus) ? '0 : (r + 12'd1);
      a.ok = 3'b111;
      case (mode)
         gncg_pkg::EDGE_CLAMP: begin
            a.v[gncg_pkg::OFF_NEG]  = (c_ext == '0) ? '0 : clamp_hi(c_dec, size_last);
            a.v[gncg_pkg::OFF_ZERO] = clamp_hi(c_ext, size_last);
            a.v[gncg_pkg::OFF_POS]  = clamp_hi(c_inc, size_last);
         end
         gncg_pkg::EDGE_REFLECT: begin
            a.v[gncg_pkg::OFF_NEG]  = fold(wrap[gncg_pkg::OFF_NEG], size, modulus);
            a.v[gncg_pkg::OFF_ZERO] = fold(wrap[gncg_pkg::OFF_ZERO], size, modulus);
            a.v[gncg_pkg::OFF_POS]  = fold(wrap[gncg_pkg::OFF_POS], size, modulus);
         end
         gncg_pkg::EDGE_ABSORB: begin
            a.v[gncg_pkg::OFF_NEG]  = c_dec[gncg_pkg::COORD_W-1:0];
            a.v[gncg_pkg::OFF_ZERO] = c;
            a.v[gncg_pkg::OFF_POS]  = c_inc[gncg_pkg::COORD_W-1:0];
            a.ok[gncg_pkg::OFF_NEG]  = (c_ext != '0) && (c_dec < size);
            a.ok[gncg_pkg::OFF_ZERO] = c_ext < size;
            a.ok[gncg_pkg::OFF_POS]  = c_inc < size;
         end
         default: begin
            a.v[gncg_pkg::OFF_NEG]  = wrap[gncg_pkg::OFF_NEG][gncg_pkg::COORD_W-1:0];
            a.v[gncg_pkg::OFF_ZERO] = wrap[gncg_pkg::OFF_ZERO][gncg_pkg::COORD_W-1:0];
            a.v[gncg_pkg::OFF_POS]  = wrap[gncg_pkg::OFF_POS][gncg_pkg::COORD_W-1:0];
         end
      endcase
      return a;
   endfunction

   // Map both axes
   always_comb begin
      ax        = map_axis(in_data.cx, cfg.width, cfg.mod_x, in_data.rx, cfg.edge_mode);
      ay        = map_axis(in_data.cy, cfg.height, cfg.mod_y, in_data.ry, cfg.edge_mode);
      pl_in.nx  = ax.v;
      pl_in.okx = ax.ok;
      pl_in.ny  = ay.v;
      pl_in.oky = ay.ok;
   end

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pl_ff <= pl_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = pl_ff;

endmodule

`default_nettype wire

// ===== src/gncg_emit.sv =====
// Neighbour serialiser: holds one mapped cell and sends its neighbours one beat per
// rsp_ready cycle via an output register, marking the last. Depends on gncg_pkg.
`default_nettype none

module gncg_emit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gncg_pkg::nbr_kind_type kind,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire gncg_pkg::nbr_type      in_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [9:0]                  rsp_x,
   output logic [9:0]                  rsp_y,
   output logic                        rsp_last
);

   gncg_pkg::nbr_type hold_ff;
   logic [7:0]        mask_ff;
   logic [7:0]        mask_in;
   logic [7:0]        cand;
   logic [7:0]        rest;
   logic [2:0]        sel_idx;
   logic [3:0]        sel_off;
   logic              busy;
   logic              out_load;
   logic              take;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [9:0]        rsp_x_ff;
   logic [9:0]        rsp_y_ff;
   logic              rsp_last_ff;

   // Offset codes {dx, dy} of each slot in emission order
   function automatic logic [3:0] slot_off(input gncg_pkg::nbr_kind_type k,
                                           input logic [2:0]             idx);
      logic [3:0] o;
      o = {gncg_pkg::OFF_ZERO, gncg_pkg::OFF_ZERO};
      if (k == gncg_pkg::NBR_MOORE) begin
         case (idx)
            3'd0:    o = {gncg_pkg::OFF_NEG,  gncg_pkg::OFF_NEG};
            3'd1:    o = {gncg_pkg::OFF_ZERO, gncg_pkg::OFF_NEG};
            3'd2:    o = {gncg_pkg::OFF_POS,  gncg_pkg::OFF_NEG};
            3'd3:    o = {gncg_pkg::OFF_NEG,  gncg_pkg::OFF_ZERO};
            3'd4:    o = {gncg_pkg::OFF_POS,  gncg_pkg::OFF_ZERO};
            3'd5:    o = {gncg_pkg::OFF_NEG,  gncg_pkg::OFF_POS};
            3'd6:    o = {gncg_pkg::OFF_ZERO, gncg_pkg::OFF_POS};
            default: o = {gncg_pkg::OFF_POS,  gncg_pkg::OFF_POS};
         endcase
      end else begin
         case (idx)
            3'd0:    o = {gncg_pkg::OFF_POS,  gncg_pkg::OFF_ZERO};
            3'd1:    o = {gncg_pkg::OFF_NEG,  gncg_pkg::OFF_ZERO};
            3'd2:    o = {gncg_pkg::OFF_ZERO, gncg_pkg::OFF_POS};
            3'd3:    o = {gncg_pkg::OFF_ZERO, gncg_pkg::OFF_NEG};
            default: o = {gncg_pkg::OFF_ZERO, gncg_pkg::OFF_ZERO};
         endcase
      end
      return o;
   endfunction

   // Slots that produce a neighbour for the incoming cell
   always_comb begin
      logic [3:0] o;
      for (int i = 0; i < 8; i++) begin
         o       = slot_off(kind, 3'(i));
         cand[i] = in_data.okx[o[3:2]] && in_data.oky[o[1:0]] &&
                   ((kind == gncg_pkg::NBR_MOORE) || (i < 4));
      end
   end

   // Pick the lowest pending slot
   always_comb begin
      sel_idx = '0;
      for (int i = 7; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel_idx = 3'(i);
         end
      end
      sel_off = slot_off(kind, sel_idx);
      rest    = mask_ff & ~(8'b1 << sel_idx);
   end

   assign busy     = |mask_ff;
   assign out_load = busy && (!rsp_valid_ff || rsp_ready);
   assign in_ready = !busy || (out_load && (rest == '0));
   assign take     = in_valid && in_ready;

   always_comb begin
      if (take) begin
         mask_in = cand;
      end else if (out_load) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the cell and drive the output beat
   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff <= in_data;
      end
      if (out_load) begin
         rsp_x_ff    <= hold_ff.nx[sel_off[3:2]];
         rsp_y_ff    <= hold_ff.ny[sel_off[1:0]];
         rsp_last_ff <= (rest == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x     = rsp_x_ff;
   assign rsp_y     = rsp_y_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/grid_neighbour_coordinate_generator.sv =====
// Top level of the grid neighbour coordinate generator: configuration registers,
// remainder pipeline, border mapping and neighbour serialiser. Depends on gncg_pkg.
`default_nettype none

// Each accepted cell (x, y) yields its Moore (eight) or von Neumann (four)
// neighbours, one beat per cycle on rsp_ while rsp_tready allows, with rsp_tlast on
// the final one; under absorbing borders neighbours outside the grid are dropped
// and a cell may yield nothing. A new cell can be accepted every cycle unless the
// pipeline is stalled; the serialiser sends one neighbour a cycle while the result
// side is ready and holds a cell until its last neighbour has left, so that single
// result port sets the sustained rate. The first neighbour leaves after the cell
// passes the two remaining remainder stages, the mapping stage, the serialiser's
// hold register and its output register. Grid sizes of 0 act as 1, above 1024 as
// 1024.
// Change configuration only while no cell is in flight.
module grid_neighbour_coordinate_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [9:0] cell_x, [19:10] cell_y, [23:20] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [9:0] neighbour_x, [19:10] neighbour_y, [23:20] zero
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [10:0] csr_wdata
);

   logic [gncg_pkg::SIZE_W-1:0] width_ff;
   logic [gncg_pkg::SIZE_W-1:0] height_ff;
   gncg_pkg::edge_mode_type     edge_mode_ff;
   gncg_pkg::nbr_kind_type      kind_ff;
   gncg_pkg::cfg_type           cfg;
   logic                        rem_valid;
   logic                        rem_ready;
   gncg_pkg::rem_type           rem_data;
   logic                        map_valid;
   logic                        map_ready;
   gncg_pkg::nbr_type           map_data;
   logic [9:0]                  rsp_x;
   logic [9:0]                  rsp_y;

   // Effective side length: zero acts as one, beyond the maximum as the maximum
   function automatic logic [gncg_pkg::SIZE_W-1:0] eff_size(
         input logic [gncg_pkg::SIZE_W-1:0] size);
      logic [gncg_pkg::SIZE_W-1:0] s;
      if (size == '0) begin
         s = 11'd1;
      end else if (size > gncg_pkg::SIZE_W'(gncg_pkg::MAX_DIM)) begin
         s = gncg_pkg::SIZE_W'(gncg_pkg::MAX_DIM);
      end else begin
         s = size;
      end
      return s;
   endfunction

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 11'd64;
         height_ff    <= 11'd64;
         edge_mode_ff <= gncg_pkg::EDGE_TORUS;
         kind_ff      <= gncg_pkg::NBR_MOORE;
      end else if (csr_we) begin
         case (gncg_pkg::reg_index_type'(csr_addr))
            gncg_pkg::REG_GRID_WIDTH:  width_ff     <= csr_wdata;
            gncg_pkg::REG_GRID_HEIGHT: height_ff    <= csr_wdata;
            gncg_pkg::REG_EDGE_MODE:   edge_mode_ff <= gncg_pkg::edge_mode_type'(csr_wdata[1:0]);
            gncg_pkg::REG_NBR_KIND:    kind_ff      <= gncg_pkg::nbr_kind_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   // Reflect repeats with period twice the size, the other rules with the size
   always_comb begin
      cfg.width     = eff_size(width_ff);
      cfg.height    = eff_size(height_ff);
      cfg.edge_mode = edge_mode_ff;
      cfg.kind      = kind_ff;
      if (edge_mode_ff == gncg_pkg::EDGE_REFLECT) begin
         cfg.mod_x = {cfg.width, 1'b0};
         cfg.mod_y = {cfg.height, 1'b0};
      end else begin
         cfg.mod_x = {1'b0, cfg.width};
         cfg.mod_y = {1'b0, cfg.height};
      end
   end

   gncg_rem_pipe u_rem (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cx     (req_tdata[9:0]),
      .in_cy     (req_tdata[19:10]),
      .out_valid (rem_valid),
      .out_ready (rem_ready),
      .out_data  (rem_data)
   );

   gncg_map u_map (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (rem_valid),
      .in_ready  (rem_ready),
      .in_data   (rem_data),
      .out_valid (map_valid),
      .out_ready (map_ready),
      .out_data  (map_data)
   );

   gncg_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .kind      (kind_ff),
      .in_valid  (map_valid),
      .in_ready  (map_ready),
      .in_data   (map_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_x     (rsp_x),
      .rsp_y     (rsp_y),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, rsp_y, rsp_x};

endmodule

`default_nettype wire

// ===== dv/neighbour_checker.sv =====
// Neighbour checker: watches the cell, result and register ports of the generator,
// predicts every neighbour beat and compares it with what the block sends.
// Depends on gncg_pkg for the register indexes, border rules and neighbourhood kinds.
`default_nettype none

module neighbour_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,   // [9:0] cell_x, [19:10] cell_y, [23:20] zero
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,   // [9:0] neighbour_x, [19:10] neighbour_y, [23:20] zero
   input  wire logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [10:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import gncg_pkg::*;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } nbr_beat_t;

   nbr_beat_t     nbr_queue[$];
   logic [10:0]   grid_w;
   logic [10:0]   grid_h;
   edge_mode_type border;
   nbr_kind_type  hood;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // A size of zero behaves as one, anything past the largest side as that side
   function automatic int clip_size(input logic [10:0] size);
      if (size == 11'd0) return 1;
      if (int'(size) > MAX_DIM) return MAX_DIM;
      return int'(size);
   endfunction

   function automatic int wrap_into(input int v, input int m);
      int r;
      r = v % m;
      return (r < 0) ? r + m : r;
   endfunction

   // Fold one axis back into the grid under the torus, clamp or reflect rule
   function automatic int fold_axis(input int v, input int m, input edge_mode_type rule);
      int r;
      case (rule)
         EDGE_CLAMP: begin
            if (v < 0) return 0;
            if (v > m - 1) return m - 1;
            return v;
         end
         EDGE_REFLECT: begin
            r = wrap_into(v, 2 * m);
            return (r >= m) ? (2 * m - 1 - r) : r;
         end
         default: return wrap_into(v, m);
      endcase
   endfunction

   // Queue the neighbour beats that one accepted cell should produce
   task automatic predict_neighbours(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
      int        ox[8];
      int        oy[8];
      int        n_offs;
      int        count;
      int        w;
      int        h;
      int        rx;
      int        ry;
      int        nx;
      int        ny;
      nbr_beat_t beats[8];
      w      = clip_size(grid_w);
      h      = clip_size(grid_h);
      n_offs = 0;
      count  = 0;
      if (hood == NBR_MOORE) begin
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
               if (dx != 0 || dy != 0) begin
                  ox[n_offs] = dx;
                  oy[n_offs] = dy;
                  n_offs++;
               end
            end
         end
      end else begin
         // +x, -x, +y, -y
         ox[0] = 1;  oy[0] = 0;
         ox[1] = -1; oy[1] = 0;
         ox[2] = 0;  oy[2] = 1;
         ox[3] = 0;  oy[3] = -1;
         n_offs = 4;
      end
      for (int k = 0; k < n_offs; k++) begin
         rx = int'(cx) + ox[k];
         ry = int'(cy) + oy[k];
         if (border == EDGE_ABSORB) begin
            // drop anything that lands off the grid
            if (rx >= 0 && rx < w && ry >= 0 && ry < h) begin
               beats[count].x    = rx[COORD_W-1:0];
               beats[count].y    = ry[COORD_W-1:0];
               beats[count].last = 1'b0;
               count++;
            end
         end else begin
            nx = fold_axis(rx, w, border);
            ny = fold_axis(ry, h, border);
            beats[count].x    = nx[COORD_W-1:0];
            beats[count].y    = ny[COORD_W-1:0];
            beats[count].last = 1'b0;
            count++;
         end
      end
      if (count > 0) beats[count-1].last = 1'b1;
      for (int k = 0; k < count; k++) nbr_queue.push_back(beats[k]);
   endtask

   // Compare one result beat with the oldest expectation
   task automatic check_beat();
      nbr_beat_t want;
      if (nbr_queue.size() == 0) begin
         $error("unexpected neighbour beat: x %0d y %0d last %0b",
                rsp_tdata[9:0], rsp_tdata[19:10], rsp_tlast);
         fail_count++;
      end else begin
         want = nbr_queue.pop_front();
         if (rsp_tdata[9:0] !== want.x) begin
            $error("neighbour_x: expected %0d, actual %0d", want.x, rsp_tdata[9:0]);
            fail_count++;
         end
         if (rsp_tdata[19:10] !== want.y) begin
            $error("neighbour_y: expected %0d, actual %0d", want.y, rsp_tdata[19:10]);
            fail_count++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
            fail_count++;
         end
      end
   endtask

   // Track register writes, predict on each cell beat, check each result beat
   always @(posedge clock) begin
      if (reset) begin
         grid_w = 11'd64;
         grid_h = 11'd64;
         border = EDGE_TORUS;
         hood   = NBR_MOORE;
         nbr_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         if (req_tvalid && req_tready) predict_neighbours(req_tdata[9:0], req_tdata[19:10]);
         if (csr_we) begin
            case (csr_addr)
               REG_GRID_WIDTH:  grid_w = csr_wdata;
               REG_GRID_HEIGHT: grid_h = csr_wdata;
               REG_EDGE_MODE:   border = edge_mode_type'(csr_wdata[1:0]);
               REG_NBR_KIND:    hood   = nbr_kind_type'(csr_wdata[0]);
               default: ;
            endcase
         end
      end
      pending_count <= nbr_queue.size();
   end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench top for the grid neighbour coordinate generator: clock, reset, cell
// stimulus, result back-pressure and register writes. Uses gncg_pkg, the block and
// neighbour_checker, which does all prediction and comparison.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gncg_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int RANDOM_PHASES   = 8;
   localparam int CELLS_PER_PHASE = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = REG_GRID_WIDTH;
   logic [10:0] csr_wdata  = '0;

   int          fail_count;
   int          pending_count;
   int          cycle_count  = 0;
   int          burst_left   = 5;
   logic        hold_off_req = 1'b0;
   logic [10:0] cur_width    = 11'd64;
   logic [10:0] cur_height   = 11'd64;

   grid_neighbour_coordinate_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   neighbour_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Give up once the run has gone far past its slowest plausible length
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Back-pressure on the result side: segments of free flow, random stalls and a
   // fixed pattern, plus one long hold-off when the stimulus asks for it
   initial begin : result_stall
      int   seg_mode;
      int   seg_len;
      int   tick;
      logic hold_taken;
      tick       = 0;
      hold_taken = 1'b0;
      forever begin
         seg_mode = $urandom_range(0, 3);
         seg_len  = $urandom_range(5, 40);
         repeat (seg_len) begin
            @(posedge clock);
            tick++;
            if (hold_off_req && !hold_taken) begin
               hold_taken = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
            end else begin
               case (seg_mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  2:       rsp_tready <= (tick % 3) != 0;
                  default: rsp_tready <= $urandom_range(0, 3) != 0;
               endcase
            end
         end
      end
   end

   // Offer one cell and hold it until accepted; close the burst with a gap
   task automatic drive_cell(input logic [9:0] x, input logic [9:0] y);
      req_tdata  <= {4'd0, y, x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Drop valid, drain every expected beat, then allow the pipeline to empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back while the block is idle
   task automatic program_grid(input logic [10:0] w, input logic [10:0] h,
                               input edge_mode_type rule, input nbr_kind_type kind);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= REG_GRID_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr  <= REG_GRID_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_addr  <= REG_EDGE_MODE;
      csr_wdata <= {9'd0, rule};
      @(posedge clock);
      csr_addr  <= REG_NBR_KIND;
      csr_wdata <= {10'd0, kind};
      @(posedge clock);
      csr_we     <= 1'b0;
      cur_width  = w;
      cur_height = h;
   endtask

   // Mostly small grids, with the extremes and out-of-range sizes now and then
   function automatic logic [10:0] pick_size();
      case ($urandom_range(0, 11))
         0:       return 11'd0;
         1:       return 11'd1;
         2:       return 11'd1024;
         3:       return 11'($urandom_range(1025, 2047));
         4:       return 11'($urandom_range(0, 2047));
         5:       return 11'd2;
         default: return 11'($urandom_range(1, 16));
      endcase
   endfunction

   // Bias the centre towards the borders; now and then anywhere in the field
   function automatic logic [9:0] pick_coord(input logic [10:0] size);
      int top_c;
      top_c = (size == 11'd0) ? 0 : ((int'(size) > MAX_DIM) ? MAX_DIM - 1 : int'(size) - 1);
      case ($urandom_range(0, 9))
         0:       return 10'd0;
         1:       return top_c[9:0];
         2:       return 10'($urandom_range(0, 1023));
         3:       return (top_c > 0) ? top_c[9:0] - 10'd1 : 10'd0;
         default: return 10'($urandom_range(0, top_c));
      endcase
   endfunction

   initial begin
      wait (!reset);
      @(posedge clock);

      // reset settings: 64 x 64 torus, Moore; one centre well outside the grid
      drive_cell(10'd0, 10'd0);
      drive_cell(10'd63, 10'd63);
      drive_cell(10'd1023, 10'd1023);
      drive_cell(10'd64, 10'd0);

      // largest grid, wrap at both corners
      program_grid(11'd1024, 11'd1024, EDGE_TORUS, NBR_MOORE);
      drive_cell(10'd0, 10'd0);
      drive_cell(10'd1023, 10'd1023);
      drive_cell(10'd512, 10'd0);

      // clamp on a small grid, corners and a centre outside it
      program_grid(11'd5, 11'd3, EDGE_CLAMP, NBR_MOORE);
      drive_cell(10'd0, 10'd0);
      drive_cell(10'd4, 10'd2);
      drive_cell(10'd2, 10'd1);
      drive_cell(10'd900, 10'd900);

      // reflect with an oversized width and a zero height
      program_grid(11'd2047, 11'd0, EDGE_REFLECT, NBR_MOORE);
      drive_cell(10'd1023, 10'd0);
      drive_cell(10'd0, 10'd0);

      // reflect on a 3 x 3 grid, including a centre far outside
      program_grid(11'd3, 11'd3, EDGE_REFLECT, NBR_MOORE);
      drive_cell(10'd0, 10'd2);
      drive_cell(10'd700, 10'd5);

      // absorbing on a single cell: no beats at all
      program_grid(11'd1, 11'd1, EDGE_ABSORB, NBR_MOORE);
      drive_cell(10'd0, 10'd0);
      drive_cell(10'd5, 10'd5);

      // absorbing on 4 x 4: corners lose neighbours, far outside loses all
      program_grid(11'd4, 11'd4, EDGE_ABSORB, NBR_MOORE);
      drive_cell(10'd0, 10'd0);
      drive_cell(10'd3, 10'd3);
      drive_cell(10'd1000, 10'd1000);

      // von Neumann under each border rule
      program_grid(11'd1, 11'd1, EDGE_TORUS, NBR_VON_NEUMANN);
      drive_cell(10'd0, 10'd0);
      program_grid(11'd1024, 11'd1024, EDGE_CLAMP, NBR_VON_NEUMANN);
      drive_cell(10'd1023, 10'd0);
      program_grid(11'd7, 11'd9, EDGE_REFLECT, NBR_VON_NEUMANN);
      drive_cell(10'd0, 10'd8);
      program_grid(11'd10, 11'd10, EDGE_ABSORB, NBR_VON_NEUMANN);
      drive_cell(10'd0, 10'd9);
      drive_cell(10'd5, 10'd5);

      // random settings, each with a run of cells; one fixed phase under a long hold-off
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 3) begin
            // every cell yields eight beats, so the block fills during the hold-off
            program_grid(11'd16, 11'd16, EDGE_TORUS, NBR_MOORE);
            hold_off_req = 1'b1;
         end else begin
            program_grid(pick_size(), pick_size(), edge_mode_type'($urandom_range(0, 3)),
                         nbr_kind_type'($urandom_range(0, 1)));
         end
         repeat (CELLS_PER_PHASE) drive_cell(pick_coord(cur_width), pick_coord(cur_height));
      end

      settle();
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
src/gncg_pkg.sv
src/gncg_rem_pipe.sv
src/gncg_map.sv
src/gncg_emit.sv
src/grid_neighbour_coordinate_generator.sv
dv/neighbour_checker.sv
dv/tb_top.sv
